### hdl/rayuv_pkg.sv
// rayuv_pkg: shared types and constants for the rgb to keyed ayuv 3:5:4:4 pixel pipeline
// q12 bt.601 coefficients, pipeline stage structs, quantiser limits
// no dependencies
package rayuv_pkg;

  // pixel component width
  localparam int unsigned COMP_W = 8;
  // q12 fraction bits
  localparam int unsigned Q_SHIFT = 12;
  // width of one coefficient-times-component product (all fit below 2^20)
  localparam int unsigned PROD_W = 20;
  // width of a signed sum, v spans roughly -2^17 .. 2^20
  localparam int unsigned SUM_W = 22;

  // q12 coefficient magnitudes, signs are applied in the adder stage
  localparam logic [11:0] CY_R = 12'd1225;
  localparam logic [11:0] CY_G = 12'd2404;
  localparam logic [11:0] CY_B = 12'd467;
  localparam logic [11:0] CU_R = 12'd602;
  localparam logic [11:0] CU_G = 12'd1184;
  localparam logic [11:0] CU_B = 12'd1786;
  localparam logic [11:0] CV_R = 12'd2519;
  localparam logic [11:0] CV_G = 12'd2109;
  localparam logic [11:0] CV_B = 12'd410;

  // +128 chroma offset in q12
  localparam logic [SUM_W-1:0] UV_OFFSET_Q = 22'sd524288;

  // near-white key thresholds
  localparam logic [COMP_W-1:0] KEY_RED_MIN   = 8'hf8;
  localparam logic [COMP_W-1:0] KEY_GREEN_MIN = 8'hfc;
  localparam logic [COMP_W-1:0] KEY_BLUE_MIN  = 8'hf8;

  // quantiser limits and rounding terms
  localparam logic [4:0] Y_TOP  = 5'd31;
  localparam logic [3:0] UV_TOP = 4'd15;
  localparam logic [8:0] Y_ROUND  = 9'd4;
  localparam logic [9:0] UV_ROUND = 10'd8;

  // 0xff quantised to 3 bits
  localparam logic [2:0] ALPHA_OPAQUE = 3'd7;
  localparam logic [2:0] ALPHA_CLEAR  = 3'd0;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_ENABLE = 2'd0;
  localparam logic [1:0] REG_FORE_RED   = 2'd1;
  localparam logic [1:0] REG_FORE_GREEN = 2'd2;
  localparam logic [1:0] REG_FORE_BLUE  = 2'd3;

  // control travelling with each item
  typedef struct packed {
    logic valid;
    logic hit;
  } ctl_t;

  // stage 1 -> stage 2: products
  typedef struct packed {
    ctl_t              ctl;
    logic [PROD_W-1:0] yr;
    logic [PROD_W-1:0] yg;
    logic [PROD_W-1:0] yb;
    logic [PROD_W-1:0] ur;
    logic [PROD_W-1:0] ug;
    logic [PROD_W-1:0] ub;
    logic [PROD_W-1:0] vr;
    logic [PROD_W-1:0] vg;
    logic [PROD_W-1:0] vb;
  } prod_t;

  // stage 2 -> stage 3: q12 sums
  typedef struct packed {
    ctl_t                    ctl;
    logic signed [SUM_W-1:0] ys;
    logic signed [SUM_W-1:0] us;
    logic signed [SUM_W-1:0] vs;
  } sum_t;

endpackage

### hdl/rgb_to_ayuv3544_keyed_pixel.sv
// rgb_to_ayuv3544_keyed_pixel: top level of the rgb to keyed ayuv 3:5:4:4 converter
// depends on rayuv_pkg, rayuv_mult, rayuv_sum, rayuv_quant
//
// usage
//   input channel: drive red, green, blue and raise start; an item is taken
//   at every rising edge where start is high and busy is low. busy is always
//   low, so one pixel can be taken in every cycle.
//   result channel: done is high for exactly one cycle per item, with
//   chroma_byte, alpha_luma_byte and keyed valid in that cycle. the receiver
//   has no way to stall, results simply flow out.
//   pipeline: each taken item goes through three register stages (constant
//   products, q12 sums, quantise and pack); throughput is one item per cycle.
//   configuration: cfg_valid / cfg_ready write channel, cfg_index picks the
//   register (0 key_enable, 1 fore_red, 2 fore_green, 3 fore_blue), cfg_data
//   is masked to the register width. cfg_ready is always high. write only
//   while no item is in flight.
//   reset: synchronous rst clears all registers but the output bytes and keyed
//   to 0 and empties the pipeline so no done pulse follows reset.
module rgb_to_ayuv3544_keyed_pixel (
  input  logic       clk,
  input  logic       rst,
  // pixel in
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // result out
  output logic       done,
  output logic [7:0] chroma_byte,
  output logic [7:0] alpha_luma_byte,
  output logic       keyed
);

  // configuration registers
  logic       key_enable;
  logic [7:0] fore_red;
  logic [7:0] fore_green;
  logic [7:0] fore_blue;

  logic              in_accept;
  rayuv_pkg::prod_t  prod;
  rayuv_pkg::sum_t   sum;

  // fully pipelined, never back-pressures either channel
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  // register file, one write per handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      key_enable <= 1'b0;
      fore_red   <= '0;
      fore_green <= '0;
      fore_blue  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rayuv_pkg::REG_KEY_ENABLE: key_enable <= cfg_data[0];
        rayuv_pkg::REG_FORE_RED:   fore_red   <= cfg_data;
        rayuv_pkg::REG_FORE_GREEN: fore_green <= cfg_data;
        rayuv_pkg::REG_FORE_BLUE:  fore_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: constant products plus key hit
  rayuv_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_accept),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .key_enable (key_enable),
    .fore_red   (fore_red),
    .fore_green (fore_green),
    .fore_blue  (fore_blue),
    .prod       (prod)
  );

  // stage 2: q12 sums with the chroma offset
  rayuv_sum u_sum (
    .clk  (clk),
    .rst  (rst),
    .prod (prod),
    .sum  (sum)
  );

  // stage 3: truncate, quantise, clamp, pack into the output register
  rayuv_quant u_quant (
    .clk             (clk),
    .rst             (rst),
    .sum             (sum),
    .done            (done),
    .chroma_byte     (chroma_byte),
    .alpha_luma_byte (alpha_luma_byte),
    .keyed           (keyed)
  );

  // every accepted item comes out as a done pulse
  a_latency : assert property (@(posedge clk) disable iff (rst)
    in_accept |-> ##3 done)
    else $error("accepted item did not produce a result after three cycles");

  // a result strobe always traces back to an accepted item
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_accept, 3))
    else $error("result strobe without a matching accepted item");

  // alpha field agrees with the keyed flag
  a_alpha_keyed : assert property (@(posedge clk) disable iff (rst)
    done |-> (keyed ? (alpha_luma_byte[7:5] == rayuv_pkg::ALPHA_CLEAR)
                    : (alpha_luma_byte[7:5] == rayuv_pkg::ALPHA_OPAQUE)))
    else $error("alpha does not match keyed flag");

endmodule

### hdl/rayuv_mult.sv
// rayuv_mult: first pipeline stage, constant products and key detection
// depends on rayuv_pkg
module rayuv_mult (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [rayuv_pkg::COMP_W-1:0]   red,
  input  logic [rayuv_pkg::COMP_W-1:0]   green,
  input  logic [rayuv_pkg::COMP_W-1:0]   blue,
  input  logic                           key_enable,
  input  logic [rayuv_pkg::COMP_W-1:0]   fore_red,
  input  logic [rayuv_pkg::COMP_W-1:0]   fore_green,
  input  logic [rayuv_pkg::COMP_W-1:0]   fore_blue,
  output rayuv_pkg::prod_t               prod
);

  rayuv_pkg::prod_t prod_next;
  logic             fore_black;
  logic             near_white;
  logic             black;

  function automatic logic [rayuv_pkg::PROD_W-1:0] cmul(
    input logic [rayuv_pkg::COMP_W-1:0] c,
    input logic [11:0]                  k
  );
    logic [rayuv_pkg::PROD_W-1:0] p;
    p = rayuv_pkg::PROD_W'(c) * rayuv_pkg::PROD_W'(k);
    return p;
  endfunction

  always_comb begin
    fore_black = (fore_red == '0) && (fore_green == '0) && (fore_blue == '0);
    near_white = (red >= rayuv_pkg::KEY_RED_MIN) && (green >= rayuv_pkg::KEY_GREEN_MIN)
                 && (blue >= rayuv_pkg::KEY_BLUE_MIN);
    black      = (red == '0) && (green == '0) && (blue == '0);

    prod_next.ctl.valid = in_valid;
    prod_next.ctl.hit   = key_enable && (fore_black ? near_white : black);
    prod_next.yr = cmul(red,   rayuv_pkg::CY_R);
    prod_next.yg = cmul(green, rayuv_pkg::CY_G);
    prod_next.yb = cmul(blue,  rayuv_pkg::CY_B);
    prod_next.ur = cmul(red,   rayuv_pkg::CU_R);
    prod_next.ug = cmul(green, rayuv_pkg::CU_G);
    prod_next.ub = cmul(blue,  rayuv_pkg::CU_B);
    prod_next.vr = cmul(red,   rayuv_pkg::CV_R);
    prod_next.vg = cmul(green, rayuv_pkg::CV_G);
    prod_next.vb = cmul(blue,  rayuv_pkg::CV_B);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod <= '0;
    end else begin
      prod <= prod_next;
    end
  end

endmodule

### hdl/rayuv_sum.sv
// rayuv_sum: second pipeline stage, signed q12 sums of the products
// depends on rayuv_pkg
module rayuv_sum (
  input  logic              clk,
  input  logic              rst,
  input  rayuv_pkg::prod_t  prod,
  output rayuv_pkg::sum_t   sum
);

  rayuv_pkg::sum_t sum_next;

  function automatic logic signed [rayuv_pkg::SUM_W-1:0] ext(
    input logic [rayuv_pkg::PROD_W-1:0] p
  );
    logic signed [rayuv_pkg::SUM_W-1:0] s;
    s = $signed({{(rayuv_pkg::SUM_W - rayuv_pkg::PROD_W){1'b0}}, p});
    return s;
  endfunction

  always_comb begin
    sum_next.ctl = prod.ctl;
    sum_next.ys  = ext(prod.yr) + ext(prod.yg) + ext(prod.yb);
    sum_next.us  = $signed(rayuv_pkg::UV_OFFSET_Q) + ext(prod.ub) - ext(prod.ur)
                   - ext(prod.ug);
    sum_next.vs  = $signed(rayuv_pkg::UV_OFFSET_Q) + ext(prod.vr) - ext(prod.vg)
                   - ext(prod.vb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else begin
      sum <= sum_next;
    end
  end

endmodule

### hdl/rayuv_quant.sv
// rayuv_quant: third pipeline stage, truncation, quantising, clamping and packing
// depends on rayuv_pkg
module rayuv_quant (
  input  logic             clk,
  input  logic             rst,
  input  rayuv_pkg::sum_t  sum,
  output logic             done,
  output logic [7:0]       chroma_byte,
  output logic [7:0]       alpha_luma_byte,
  output logic             keyed
);

  logic [8:0] y_int;
  logic [8:0] u_int;
  logic [8:0] v_int;
  logic [8:0] y_rnd;
  logic [9:0] u_rnd;
  logic [9:0] v_rnd;
  logic [4:0] y_q;
  logic [3:0] u_q;
  logic [3:0] v_q;
  logic [2:0] alpha;

  always_comb begin
    // y and u sums are never negative, v clamps to zero below
    y_int = {1'b0, sum.ys[rayuv_pkg::Q_SHIFT +: 8]};
    u_int = {1'b0, sum.us[rayuv_pkg::Q_SHIFT +: 8]};
    v_int = sum.vs[rayuv_pkg::SUM_W-1] ? 9'd0 : sum.vs[rayuv_pkg::Q_SHIFT +: 9];

    y_rnd = y_int + rayuv_pkg::Y_ROUND;
    u_rnd = {1'b0, u_int} + rayuv_pkg::UV_ROUND;
    v_rnd = {1'b0, v_int} + rayuv_pkg::UV_ROUND;

    y_q = (y_rnd[8:3] > 6'(rayuv_pkg::Y_TOP)) ? rayuv_pkg::Y_TOP : y_rnd[7:3];
    u_q = (u_rnd[9:4] > 6'(rayuv_pkg::UV_TOP)) ? rayuv_pkg::UV_TOP : u_rnd[7:4];
    v_q = (v_rnd[9:4] > 6'(rayuv_pkg::UV_TOP)) ? rayuv_pkg::UV_TOP : v_rnd[7:4];

    alpha = sum.ctl.hit ? rayuv_pkg::ALPHA_CLEAR : rayuv_pkg::ALPHA_OPAQUE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sum.ctl.valid;
    end
    chroma_byte     <= {u_q, v_q};
    alpha_luma_byte <= {alpha, y_q};
    keyed           <= sum.ctl.hit;
  end

endmodule

### sim/ayuv_score_pkg.sv
`timescale 1ns / 100ps
// ayuv_score_pkg: scoreboard class that predicts and checks keyed ayuv 3:5:4:4 pixels
// depends on rayuv_pkg for the configuration register indexes
package ayuv_score_pkg;

  typedef struct packed {
    logic [7:0] chroma;
    logic [7:0] alpha_luma;
    logic       keyed;
  } osd_pixel_t;

  class pixel_scoreboard;

    logic          key_en;
    logic [7:0]    fore_r;
    logic [7:0]    fore_g;
    logic [7:0]    fore_b;
    osd_pixel_t    awaited[$];
    int            errors;

    function new();
      key_en = 1'b0;
      fore_r = '0;
      fore_g = '0;
      fore_b = '0;
      errors = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] data);
      case (idx)
        rayuv_pkg::REG_KEY_ENABLE: key_en = data[0];
        rayuv_pkg::REG_FORE_RED:   fore_r = data;
        rayuv_pkg::REG_FORE_GREEN: fore_g = data;
        rayuv_pkg::REG_FORE_BLUE:  fore_b = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // (x*scale+128)>>8 with a top clamp
    function int unsigned quantise(int unsigned x, int unsigned scale, int unsigned top);
      int unsigned q;
      q = (x * scale + 128) >> 8;
      return (q > top) ? top : q;
    endfunction

    // bt.601 analog in q12, sums truncated, negative v floored at 0
    function osd_pixel_t convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
      int          r, g, b;
      int          ys, us, vs;
      int unsigned y, u, v, a;
      logic        hit;
      osd_pixel_t  px;
      r = int'(r8);
      g = int'(g8);
      b = int'(b8);
      if ((fore_r | fore_g | fore_b) == 8'd0)
        hit = (r8 >= 8'hf8) && (g8 >= 8'hfc) && (b8 >= 8'hf8);
      else
        hit = (r8 == 8'd0) && (g8 == 8'd0) && (b8 == 8'd0);
      hit = hit && key_en;
      ys = 1225 * r + 2404 * g + 467 * b;
      us = -602 * r - 1184 * g + 1786 * b + 524288;
      vs = 2519 * r - 2109 * g - 410 * b + 524288;
      y = quantise(ys >>> 12, 32, 31);
      u = quantise(us >>> 12, 16, 15);
      v = (vs < 0) ? 0 : quantise(vs >>> 12, 16, 15);
      a = hit ? 0 : quantise(255, 8, 7);
      px.chroma     = {u[3:0], v[3:0]};
      px.alpha_luma = {a[2:0], y[4:0]};
      px.keyed      = hit;
      return px;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      awaited.push_back(convert_pixel(r, g, b));
    endfunction

    function void check_result(logic [7:0] chroma, logic [7:0] alpha_luma, logic keyed);
      osd_pixel_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing outstanding: chroma_byte %h alpha_luma_byte %h keyed %b",
               chroma, alpha_luma, keyed);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (chroma !== want.chroma) begin
        $error("chroma_byte: expected %h, got %h", want.chroma, chroma);
        errors++;
      end
      if (alpha_luma !== want.alpha_luma) begin
        $error("alpha_luma_byte: expected %h, got %h", want.alpha_luma, alpha_luma);
        errors++;
      end
      if (keyed !== want.keyed) begin
        $error("keyed: expected %b, got %b", want.keyed, keyed);
        errors++;
      end
    endfunction

  endclass

endpackage

### sim/tb_rgb_to_ayuv3544_keyed_pixel.sv
`timescale 1ns / 100ps
// tb_rgb_to_ayuv3544_keyed_pixel: self-checking bench for the keyed ayuv pixel converter
// depends on rayuv_pkg, ayuv_score_pkg and the rgb_to_ayuv3544_keyed_pixel rtl
module tb_rgb_to_ayuv3544_keyed_pixel;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = rayuv_pkg::REG_KEY_ENABLE;
  logic [7:0] cfg_data = '0;
  logic       done;
  logic [7:0] chroma_byte;
  logic [7:0] alpha_luma_byte;
  logic       keyed;

  // chance in a hundred that the sender holds off before an item
  int unsigned send_idle_pct = 0;

  ayuv_score_pkg::pixel_scoreboard sb = new();

  rgb_to_ayuv3544_keyed_pixel u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .chroma_byte     (chroma_byte),
    .alpha_luma_byte (alpha_luma_byte),
    .keyed           (keyed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // monitors: at the edge they see the values that the edge itself samples,
  // since every input here and every registered output changes by nba
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready)
      sb.set_register(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_pixel(red, green, blue);
  end

  // the receiver cannot stall, every done pulse is a result
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(chroma_byte, alpha_luma_byte, keyed);
  end

  // present one pixel, with random hold-off first, and hold it until taken;
  // start is left high so back-to-back items need no gap
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    red   <= r;
    green <= g;
    blue  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // pixel mix: near-white around the key threshold, black and near-black,
  // saturated colours with each component 00 or ff, and plain random for bit coverage
  task automatic send_random_pixel();
    int unsigned kind;
    logic [7:0]  r, g, b;
    kind = $urandom_range(0, 99);
    r = 8'($urandom_range(0, 255));
    g = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    if (kind < 25) begin
      r = 8'($urandom_range(8'hf4, 8'hff));
      g = 8'($urandom_range(8'hf8, 8'hff));
      b = 8'($urandom_range(8'hf4, 8'hff));
    end else if (kind < 40) begin
      r = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1)) : 8'd0;
      g = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1)) : 8'd0;
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1)) : 8'd0;
    end else if (kind < 50) begin
      r = $urandom_range(0, 1) ? 8'hff : 8'h00;
      g = $urandom_range(0, 1) ? 8'hff : 8'h00;
      b = $urandom_range(0, 1) ? 8'hff : 8'h00;
    end
    send_pixel(r, g, b);
  endtask

  // stop sending and wait for every outstanding result; the extra edge
  // makes sure the last taken item is already in the scoreboard
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // consecutive writes keep valid high, so it is lowered only at the end
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic en, input logic [7:0] fr, input logic [7:0] fg,
                           input logic [7:0] fb);
    write_reg(rayuv_pkg::REG_KEY_ENABLE, {7'($urandom_range(0, 127)), en});
    write_reg(rayuv_pkg::REG_FORE_RED, fr);
    write_reg(rayuv_pkg::REG_FORE_GREEN, fg);
    write_reg(rayuv_pkg::REG_FORE_BLUE, fb);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned idle_plan[3];
    logic [7:0]  fr, fg, fb;
    idle_plan = '{13, 67, 0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: black foreground, keying on, so near-white is keyed
    configure(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);   // y saturates
    send_pixel(8'hf8, 8'hfc, 8'hf8);   // exactly on the key threshold
    send_pixel(8'hf7, 8'hfc, 8'hf8);   // each component just below it
    send_pixel(8'hf8, 8'hfb, 8'hf8);
    send_pixel(8'hf8, 8'hfc, 8'hf7);
    send_pixel(8'hff, 8'h00, 8'h00);   // v saturates
    send_pixel(8'h00, 8'hff, 8'h00);   // negative v sum floors at 0
    send_pixel(8'h00, 8'h00, 8'hff);   // u saturates
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h00);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'h01, 8'h01, 8'h01);
    send_pixel(8'h00, 8'h00, 8'h01);
    wait_for_results();

    // directed: coloured foreground, so only pure black is keyed
    configure(1'b1, 8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h01);
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'hf8, 8'hfc, 8'hf8);
    wait_for_results();

    // directed: keying off, neither candidate is keyed
    configure(1'b0, 8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    wait_for_results();

    // random: three idling phases, each through several register settings,
    // every setting change made with the pipeline empty
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = idle_plan[ph];
      for (int blk = 0; blk < 4; blk++) begin
        wait_for_results();
        if (blk == 0) begin
          configure(1'b1, 8'hff, 8'hff, 8'hff);
        end else if (blk == 1) begin
          configure(1'b1, 8'h00, 8'h00, 8'h00);
        end else begin
          // foreground black half the time, otherwise random with zeros likely
          fr = 8'($urandom_range(0, 255));
          fg = 8'($urandom_range(0, 255));
          fb = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 1) == 0) begin
            fr = 8'h00;
            fg = 8'h00;
            fb = 8'h00;
          end else if ($urandom_range(0, 2) == 0) begin
            fr = 8'h00;
            fb = 8'h00;
          end
          configure(1'($urandom_range(0, 1)), fr, fg, fb);
        end
        for (int n = 0; n < 46; n++)
          send_random_pixel();
      end
    end

    wait_for_results();
    // keep clocking so a stray done pulse would still be caught
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
